### rtl/ibc_pkg.sv
package ibc_pkg;

  // batch limit and the widths that follow from it
  localparam int MAX_BATCH = 64;
  localparam int CNT_W     = $clog2(MAX_BATCH + 1);
  localparam int SUM_W     = 17 + $clog2(MAX_BATCH);
  localparam int SAMPLE_W  = 16;
  localparam int ONE_G_W   = 15;
  localparam int NUM_AXES  = 6;
  localparam int NUM_MAG   = 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_CAL_AG  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CAL_MAG = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READING  = 2'd0,
    KIND_AG_BIAS  = 2'd1,
    KIND_MAG_BIAS = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CORRECT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_G        = 1'b1;

  typedef logic signed [SUM_W-1:0] acc_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    acc_t    a;
    acc_t    b;
  } alu_req_t;

  typedef struct packed {
    logic             start;
    acc_t             dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/ibc_alu.sv
module ibc_alu (
  input  ibc_pkg::alu_req_t req,
  output ibc_pkg::acc_t     result
);
  import ibc_pkg::*;

  always_comb begin
    case (req.op)
      ALU_ADD: result = req.a + req.b;
      ALU_SUB: result = req.a - req.b;
      default: result = req.a + req.b;
    endcase
  end

endmodule

### rtl/ibc_div.sv
module ibc_div (
  input  logic              clk,
  input  logic              rst,
  input  ibc_pkg::div_req_t req,
  output ibc_pkg::div_rsp_t rsp
);
  import ibc_pkg::*;

  localparam int MAG_W  = SUM_W;
  localparam int STEP_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]    quo;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    divisor;
  logic                neg;
  logic [STEP_W-1:0]   steps_left;
  logic                running;
  logic                done;
  logic [MAG_W-1:0]    magnitude;
  logic [CNT_W:0]      shifted;
  logic [CNT_W:0]      trial;
  logic                fits;
  logic [SAMPLE_W-1:0] q_low;

  // restoring division on the magnitude, one quotient bit per cycle
  always_comb begin
    magnitude = req.dividend[SUM_W-1] ? MAG_W'(~req.dividend + 1'b1) : MAG_W'(req.dividend);
    shifted   = {rem, quo[MAG_W-1]};
    trial     = shifted - {1'b0, divisor};
    fits      = !trial[CNT_W];
    if (divisor == '0) begin
      q_low = '0;
    end else if (neg) begin
      q_low = ~quo[SAMPLE_W-1:0] + 1'b1;
    end else begin
      q_low = quo[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running    <= 1'b1;
        quo        <= magnitude;
        rem        <= '0;
        divisor    <= req.divisor;
        neg        <= req.dividend[SUM_W-1];
        steps_left <= STEP_W'(MAG_W);
      end else if (running) begin
        quo        <= {quo[MAG_W-2:0], fits};
        rem        <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        steps_left <= steps_left - 1'b1;
        if (steps_left == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done     = done;
    rsp.quotient = q_low;
  end

endmodule

### rtl/imu_bias_calibration.sv
// channel  direction  fields (low bit first)
// s_*      in         tdata: first_x/y/z, second_x/y/z; tuser: command; tlast: last_sample
// m_*      out        tdata: res_first_x/y/z, res_second_x/y/z;
//                     tuser: result_kind, batch_overflow
// cfg_*    in         write enable, register index, write data
//
// one item at a time via a shared adder/subtractor, one axis per cycle except for mag
// a reading runs capture, six correction steps and result load before ready returns
// accel/gyro sample: capture, six corrections, count, seven sum steps, end check;
// mag sample: capture, count, six min/max compares, end check; a dropped sample
// skips the sums and compares. Batch end adds the shared divider, six quotients in
// turn for accel/gyro, and six adder steps for mag midpoints
// synchronous reset, no clearing pass; a held result stalls the result load and the input
module imu_bias_calibration (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [95:0]                     s_tdata,   // first_x, first_y, first_z,
                                                     // second_x, second_y, second_z
  input  logic [1:0]                      s_tuser,   // command
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [95:0]                     m_tdata,   // res_first_x/y/z, res_second_x/y/z
  output logic [2:0]                      m_tuser,   // result_kind, batch_overflow
  input  logic                            cfg_we,
  input  logic [ibc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ibc_pkg::ONE_G_W-1:0]     cfg_data
);
  import ibc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORR,
    ST_BOOK,
    ST_ACC,
    ST_MAG,
    ST_FIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MID,
    ST_EMIT
  } state_t;

  state_t                     state;
  logic [2:0]                 step;
  cmd_t                       cmd;
  logic                       last;
  kind_t                      kind;
  logic signed [SAMPLE_W-1:0] samp [NUM_AXES];
  acc_t                       sums [NUM_AXES];
  logic signed [SAMPLE_W-1:0] bias [NUM_AXES];
  logic signed [SAMPLE_W-1:0] mag_min [NUM_MAG];
  logic signed [SAMPLE_W-1:0] mag_max [NUM_MAG];
  logic signed [SAMPLE_W:0]   mid_sum;
  logic [CNT_W-1:0]           batch_count;
  logic                       correcting;
  logic                       overflow_seen;
  logic                       auto_correct_enable;
  logic [ONE_G_W-1:0]         one_g_counts;

  logic [1:0]                 axis;
  alu_req_t                   alu_req;
  acc_t                       alu_res;
  logic                       alu_neg;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  assign s_tready = (state == ST_IDLE);
  assign axis     = step[2:1];
  assign alu_neg  = alu_res[SUM_W-1];

  // operand selection for the shared adder, one axis per step, two for each mag axis
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state)
      ST_CORR: begin
        // bias subtraction, low 16 bits kept
        alu_req.op = ALU_SUB;
        alu_req.a  = acc_t'(samp[step]);
        alu_req.b  = acc_t'(bias[step]);
      end
      ST_ACC: begin
        if (step == 3'd6) begin
          // one g off accel z
          alu_req.op = ALU_SUB;
          alu_req.a  = sums[2];
          alu_req.b  = acc_t'({1'b0, one_g_counts});
        end else begin
          alu_req.a  = sums[step];
          alu_req.b  = acc_t'(samp[step]);
        end
      end
      ST_MAG: begin
        // even step: max - s < 0 means new max; odd step: s - min < 0 means new min
        alu_req.op = ALU_SUB;
        if (!step[0]) begin
          alu_req.a = acc_t'(mag_max[axis]);
          alu_req.b = acc_t'(samp[{1'b0, axis}]);
        end else begin
          alu_req.a = acc_t'(samp[{1'b0, axis}]);
          alu_req.b = acc_t'(mag_min[axis]);
        end
      end
      ST_MID: begin
        // even step: max + min; odd step: halve, rounding toward zero
        if (!step[0]) begin
          alu_req.a = acc_t'(mag_max[axis]);
          alu_req.b = acc_t'(mag_min[axis]);
        end else begin
          alu_req.a = acc_t'(mid_sum >>> 1);
          alu_req.b = acc_t'({1'b0, mid_sum[SAMPLE_W] & mid_sum[0]});
        end
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    div_req.start    = (state == ST_DIV_START);
    div_req.dividend = sums[step];
    div_req.divisor  = batch_count;
  end

  ibc_alu u_alu (
    .req    (alu_req),
    .result (alu_res)
  );

  ibc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      step                <= '0;
      m_tvalid            <= 1'b0;
      batch_count         <= '0;
      correcting          <= 1'b0;
      overflow_seen       <= 1'b0;
      auto_correct_enable <= 1'b0;
      one_g_counts        <= ONE_G_W'(5);
      for (int i = 0; i < NUM_AXES; i++) begin
        sums[i] <= '0;
        bias[i] <= '0;
      end
      for (int i = 0; i < NUM_MAG; i++) begin
        mag_min[i] <= '0;
        mag_max[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AUTO_CORRECT: auto_correct_enable <= cfg_data[0];
          CFG_ONE_G:        one_g_counts        <= cfg_data;
          default:          ;
        endcase
      end

      // the result load below owns the valid flag while in ST_EMIT
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd  <= cmd_t'(s_tuser);
            last <= s_tlast;
            step <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
              samp[i] <= s_tdata[SAMPLE_W*i +: SAMPLE_W];
            end
            case (cmd_t'(s_tuser))
              CMD_CAL_AG, CMD_READ: state <= ST_CORR;
              CMD_CAL_MAG:          state <= ST_BOOK;
              default:              state <= ST_IDLE;
            endcase
          end
        end

        ST_CORR: begin
          if (correcting) begin
            samp[step] <= alu_res[SAMPLE_W-1:0];
          end
          if (step == 3'd5) begin
            step <= '0;
            if (cmd == CMD_READ) begin
              kind  <= KIND_READING;
              state <= ST_EMIT;
            end else begin
              state <= ST_BOOK;
            end
          end else begin
            step <= step + 1'b1;
          end
        end

        ST_BOOK: begin
          // shared count for both calibration kinds; a full batch drops the sample
          if (batch_count < CNT_W'(MAX_BATCH)) begin
            batch_count <= batch_count + 1'b1;
            state       <= (cmd == CMD_CAL_AG) ? ST_ACC : ST_MAG;
          end else begin
            overflow_seen <= 1'b1;
            state         <= ST_FIN;
          end
        end

        ST_ACC: begin
          if (step == 3'd6) begin
            sums[2] <= alu_res;
            step    <= '0;
            state   <= ST_FIN;
          end else begin
            sums[step] <= alu_res;
            step       <= step + 1'b1;
          end
        end

        ST_MAG: begin
          if (alu_neg) begin
            if (!step[0]) begin
              mag_max[axis] <= samp[{1'b0, axis}];
            end else begin
              mag_min[axis] <= samp[{1'b0, axis}];
            end
          end
          if (step == 3'd5) begin
            step  <= '0;
            state <= ST_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end

        ST_FIN: begin
          step <= '0;
          if (!last) begin
            state <= ST_IDLE;
          end else if (cmd == CMD_CAL_AG) begin
            state <= ST_DIV_START;
          end else begin
            state <= ST_MID;
          end
        end

        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end

        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            bias[step] <= div_rsp.quotient;
            samp[step] <= div_rsp.quotient;
            if (step == 3'd5) begin
              step <= '0;
              if (auto_correct_enable) begin
                correcting <= 1'b1;
              end
              kind  <= KIND_AG_BIAS;
              state <= ST_EMIT;
            end else begin
              step  <= step + 1'b1;
              state <= ST_DIV_START;
            end
          end
        end

        ST_MID: begin
          if (!step[0]) begin
            mid_sum <= alu_res[SAMPLE_W:0];
          end else begin
            samp[{1'b0, axis}] <= alu_res[SAMPLE_W-1:0];
          end
          if (step == 3'd5) begin
            step <= '0;
            for (int i = NUM_MAG; i < NUM_AXES; i++) begin
              samp[i] <= '0;
            end
            kind  <= KIND_MAG_BIAS;
            state <= ST_EMIT;
          end else begin
            step <= step + 1'b1;
          end
        end

        ST_EMIT: begin
          // waits here while an earlier result is still unclaimed
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {samp[5], samp[4], samp[3], samp[2], samp[1], samp[0]};
            m_tuser  <= {(kind != KIND_READING) && overflow_seen, kind};
            if (kind != KIND_READING) begin
              // batch done: clear sums, extremes, count and overflow
              batch_count   <= '0;
              overflow_seen <= 1'b0;
              for (int i = 0; i < NUM_AXES; i++) begin
                sums[i] <= '0;
              end
              for (int i = 0; i < NUM_MAG; i++) begin
                mag_min[i] <= '0;
                mag_max[i] <= '0;
              end
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a real command leaves the block busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser != CMD_UNUSED)) |=> !s_tready)
    else $error("ready right after accepting a command");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    batch_count <= CNT_W'(MAX_BATCH))
    else $error("batch count beyond limit");

  a_reading_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[1:0] == KIND_READING)) |-> !m_tuser[2])
    else $error("overflow flag on a reading");

  a_correcting_holds: assert property (@(posedge clk) disable iff (rst)
    correcting |=> correcting)
    else $error("correction switched off");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_WAIT))
    else $error("quotient outside divide wait");

endmodule
